// ----- rtl/core/lesf_pkg.sv -----
// Shared widths, codes, reset values and types of the largest empty square finder.
package lesf_pkg;

   localparam int CHAR_W    = 8;
   localparam int SIZE_W    = 11;
   localparam int POS_W     = 10;
   localparam int ERR_W     = 2;
   localparam int CNT_W     = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 11;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_CHAR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_CHAR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_CHAR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT     = 3'd4;

   // Error codes reported in error_kind.
   localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_W-1:0] ERR_CHAR = 2'd1;
   localparam logic [ERR_W-1:0] ERR_LEN  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_DUP  = 2'd3;

   localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST    = 8'd46;
   localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = 8'd111;
   localparam logic [CHAR_W-1:0] FILL_CHAR_RST     = 8'd120;
   localparam logic [CNT_W-1:0]  ROW_COUNT_RST     = 11'd1;
   localparam logic [CNT_W-1:0]  COL_COUNT_RST     = 11'd1;

   typedef struct packed {
      logic [CHAR_W-1:0] empty_char;
      logic [CHAR_W-1:0] obstacle_char;
      logic [CHAR_W-1:0] fill_char;
      logic [CNT_W-1:0]  row_count;
      logic [CNT_W-1:0]  col_count;
   } cfg_type;

   typedef struct packed {
      logic [SIZE_W-1:0] square_here;
      logic [SIZE_W-1:0] best_size;
      logic [POS_W-1:0]  best_row;
      logic [POS_W-1:0]  best_col;
      logic [ERR_W-1:0]  error_kind;
      logic              grid_done;
   } rsp_type;

endpackage

// ----- rtl/core/lesf_if.sv -----
// Request and response channel interfaces of the largest empty square finder.
interface lesf_req_if import lesf_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] cell_char;
   logic              line_end;

   modport source (output valid, output cell_char, output line_end, input ready);
   modport sink (input valid, input cell_char, input line_end, output ready);
endinterface

interface lesf_rsp_if import lesf_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] square_here;
   logic [SIZE_W-1:0] best_size;
   logic [POS_W-1:0]  best_row;
   logic [POS_W-1:0]  best_col;
   logic [ERR_W-1:0]  error_kind;
   logic              grid_done;

   modport source (output valid, output square_here, output best_size, output best_row,
                   output best_col, output error_kind, output grid_done, input ready);
   modport sink (input valid, input square_here, input best_size, input best_row,
                 input best_col, input error_kind, input grid_done, output ready);
endinterface

// ----- rtl/core/lesf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lesf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lesf_csr.sv -----
// Configuration registers written through the plain write port.
module lesf_csr import lesf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EMPTY_CHAR:    cfg_in.empty_char    = csr_wdata[CHAR_W-1:0];
            CSR_OBSTACLE_CHAR: cfg_in.obstacle_char = csr_wdata[CHAR_W-1:0];
            CSR_FILL_CHAR:     cfg_in.fill_char     = csr_wdata[CHAR_W-1:0];
            CSR_ROW_COUNT:     cfg_in.row_count     = csr_wdata[CNT_W-1:0];
            CSR_COL_COUNT:     cfg_in.col_count     = csr_wdata[CNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.empty_char    <= EMPTY_CHAR_RST;
         cfg_ff.obstacle_char <= OBSTACLE_CHAR_RST;
         cfg_ff.fill_char     <= FILL_CHAR_RST;
         cfg_ff.row_count     <= ROW_COUNT_RST;
         cfg_ff.col_count     <= COL_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/lesf_core.sv -----
// Per-cell square size, best-square tracking, position counters and sticky error.
module lesf_core import lesf_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        req_accept,
   input  logic [CHAR_W-1:0]           cell_char,
   input  logic                        line_end,
   input  logic [SIZE_W-1:0]           line_rd_data,
   output logic [$clog2(MAX_COLS)-1:0] line_rd_addr,
   output logic                        line_wr_en,
   output logic [$clog2(MAX_COLS)-1:0] line_wr_addr,
   output logic [SIZE_W-1:0]           line_wr_data,
   output rsp_type                     result
);

   localparam int AW    = $clog2(MAX_COLS);
   localparam int COL_W = $clog2(MAX_COLS + 1);
   localparam int ROW_W = $clog2(MAX_ROWS + 1);

   logic [COL_W-1:0]  col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [SIZE_W-1:0] left_size_ff, left_size_in;
   logic [SIZE_W-1:0] diag_size_ff, diag_size_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic [POS_W-1:0]  best_row_ff, best_row_in;
   logic [POS_W-1:0]  best_col_ff, best_col_in;
   logic [ERR_W-1:0]  error_ff, error_in;
   logic              finished_ff, finished_in;

   logic [31:0]       col_count_w;
   logic [31:0]       rows_w;
   logic              held;
   logic              last_col;
   logic              last_row;
   logic [ERR_W-1:0]  err_now;
   logic              cell_ok;
   logic [SIZE_W-1:0] min_ul;
   logic [SIZE_W-1:0] min_all;
   logic [SIZE_W-1:0] here;

   always_comb begin
      col_count_w = 32'(cfg.col_count);
      last_col    = (32'(col_pos_ff) == col_count_w - 32'd1);

      // A row count of zero means one row; counts above MAX_ROWS saturate.
      if (cfg.row_count == '0) begin
         rows_w = 32'd1;
      end else if (32'(cfg.row_count) > 32'(MAX_ROWS)) begin
         rows_w = 32'(MAX_ROWS);
      end else begin
         rows_w = 32'(cfg.row_count);
      end
      last_row = (32'(row_pos_ff) + 32'd1 >= rows_w);

      held = (error_ff != ERR_NONE) || finished_ff;

      priority if (held) begin
         err_now = ERR_NONE;
      end else if (cfg.empty_char == cfg.obstacle_char || cfg.empty_char == cfg.fill_char ||
                   cfg.obstacle_char == cfg.fill_char) begin
         err_now = ERR_DUP;
      end else if (cell_char != cfg.empty_char && cell_char != cfg.obstacle_char) begin
         err_now = ERR_CHAR;
      end else if (cfg.col_count == '0 || col_count_w > 32'(MAX_COLS) ||
                   32'(col_pos_ff) >= 32'(MAX_COLS)) begin
         err_now = ERR_LEN;
      end else if (line_end != last_col) begin
         err_now = ERR_LEN;
      end else begin
         err_now = ERR_NONE;
      end
      cell_ok = !held && (err_now == ERR_NONE);

      min_ul  = (line_rd_data < left_size_ff) ? line_rd_data : left_size_ff;
      min_all = (diag_size_ff < min_ul) ? diag_size_ff : min_ul;

      if (cell_char == cfg.obstacle_char) begin
         here = '0;
      end else if (row_pos_ff == '0 || col_pos_ff == '0) begin
         here = SIZE_W'(1);
      end else begin
         here = min_all + SIZE_W'(1);
      end

      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      left_size_in = left_size_ff;
      diag_size_in = diag_size_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      error_in     = error_ff;
      finished_in  = finished_ff;
      line_wr_en   = 1'b0;

      if (req_accept) begin
         if (err_now != ERR_NONE) begin
            error_in = err_now;
         end
         if (cell_ok) begin
            line_wr_en = 1'b1;
            if (here > best_size_ff) begin
               best_size_in = here;
               best_row_in  = POS_W'(row_pos_ff);
               best_col_in  = POS_W'(col_pos_ff);
            end
            if (last_col) begin
               col_pos_in   = '0;
               left_size_in = '0;
               diag_size_in = '0;
               if (last_row) begin
                  finished_in = 1'b1;
               end else begin
                  row_pos_in = row_pos_ff + ROW_W'(1);
               end
            end else begin
               col_pos_in   = col_pos_ff + COL_W'(1);
               left_size_in = here;
               diag_size_in = line_rd_data;
            end
         end
      end

      result.square_here = cell_ok ? here : '0;
      result.best_size   = best_size_in;
      result.best_row    = best_row_in;
      result.best_col    = best_col_in;
      result.error_kind  = error_in;
      result.grid_done   = cell_ok && last_col && last_row;
   end

   // The line store is read at the position of the next cell, so its registered
   // data lines up with the column counter in the following cycle.
   assign line_rd_addr = col_pos_in[AW-1:0];
   assign line_wr_addr = col_pos_ff[AW-1:0];
   assign line_wr_data = here;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         left_size_ff <= '0;
         diag_size_ff <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         error_ff     <= ERR_NONE;
         finished_ff  <= 1'b0;
      end else begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         left_size_ff <= left_size_in;
         diag_size_ff <= diag_size_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         error_ff     <= error_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

// ----- rtl/core/lesf_skid.sv -----
// Response register with one skid entry so requests keep flowing while a response waits.
module lesf_skid import lesf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;

      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_ready) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- rtl/core/largest_empty_square_finder.sv -----
// Top level of the largest empty square finder: line store, cell logic and response buffer.
//
//   channel   direction  handshake          contents
//   req_ch    in         valid/ready        cell_char, line_end
//   rsp_ch    out        valid/ready        square_here, best_size, best_row, best_col,
//                                           error_kind, grid_done
//   csr_*     in         csr_wr_en only     csr_index, csr_wdata
//
// One request is taken per cycle unless stalled; its response is registered in the output
// or skid entry. The limit is the left-neighbor min-and-add through the line store's read.
// Reset is synchronous; the line store is not cleared, since the first row never uses it.
// A stalled response is held in the output register and one more in the skid entry;
// req_ch.ready falls only while the skid entry is occupied.
module largest_empty_square_finder import lesf_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lesf_req_if.sink             req_ch,
   lesf_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_COLS);

   cfg_type           cfg;
   logic              req_accept;
   logic              core_ready;
   logic [AW-1:0]     line_rd_addr;
   logic [AW-1:0]     line_wr_addr;
   logic              line_wr_en;
   logic [SIZE_W-1:0] line_wr_data;
   logic [SIZE_W-1:0] line_rd_data;
   rsp_type           core_result;
   rsp_type           rsp_data;

   assign req_ch.ready = core_ready;
   assign req_accept   = req_ch.valid && core_ready;

   lesf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lesf_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   lesf_core #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_accept   (req_accept),
      .cell_char    (req_ch.cell_char),
      .line_end     (req_ch.line_end),
      .line_rd_data (line_rd_data),
      .line_rd_addr (line_rd_addr),
      .line_wr_en   (line_wr_en),
      .line_wr_addr (line_wr_addr),
      .line_wr_data (line_wr_data),
      .result       (core_result)
   );

   lesf_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_ready  (core_ready),
      .in_data   (core_result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.square_here = rsp_data.square_here;
   assign rsp_ch.best_size   = rsp_data.best_size;
   assign rsp_ch.best_row    = rsp_data.best_row;
   assign rsp_ch.best_col    = rsp_data.best_col;
   assign rsp_ch.error_kind  = rsp_data.error_kind;
   assign rsp_ch.grid_done   = rsp_data.grid_done;

endmodule
